/* hw/rtl/key_matrix_scan_debounce_assert.svh */
// Assertion macros used by the checker file of the key matrix scanner.
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH

// Checked at every rising clock edge while the block is out of reset.
`define KMSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define KMSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/kmsd_pkg.sv */
package kmsd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 16;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 16;
  localparam int EXP_W   = 8;
  localparam int TIME_W  = 16;
  localparam int DEB_W   = 8;
  localparam int RETRY_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);
  localparam logic [EXP_W-1:0] EXP_MASK_RESET = '0;
  localparam logic [COL_W-1:0] OB_MASK_RESET  = '1;

  // Columns beyond COLS never show up in a row.
  localparam logic [COL_W-1:0] ROW_MASK =
    (COLS >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << COLS) - 64'd1);

  localparam logic [ROW_W-1:0] FIRST_ROW = '0;
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MS = 2'd0,
    CFG_EXP_MASK    = 2'd1,
    CFG_OB_MASK     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic [EXP_W-1:0] expander_col_mask;
    logic [COL_W-1:0] onboard_col_mask;
  } cfg_t;

  // One classified row reading as it waits between front and back.
  typedef struct packed {
    logic              in_range;
    logic [ROW_W-1:0]  row_index;
    logic [EXP_W-1:0]  exp_bits;
    logic              expander_ack;
    logic [COL_W-1:0]  ob_bits;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] debounced_row;
    logic             raw_changed;
    logic             committed;
    logic             expander_fault;
    logic             retry_request;
  } result_t;

endpackage

/* hw/rtl/kmsd_queue.sv */
module kmsd_queue
  import kmsd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // The depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/kmsd_front.sv */
module kmsd_front
  import kmsd_pkg::*;
(
  input  cfg_t              cfg_i,
  input  logic [ROW_W-1:0]  row_index_i,
  input  logic [EXP_W-1:0]  expander_levels_i,
  input  logic              expander_ack_i,
  input  logic [COL_W-1:0]  onboard_levels_i,
  input  logic [TIME_W-1:0] now_ms_i,
  output item_t             item_o
);

  // Levels are active low; invert, then keep only the columns each source owns, and flag rows outside the matrix.
  always_comb begin
    item_o.in_range     = ({1'b0, row_index_i} < (ROW_W + 1)'(ROWS));
    item_o.row_index    = row_index_i;
    item_o.exp_bits     = ~expander_levels_i & cfg_i.expander_col_mask;
    item_o.expander_ack = expander_ack_i;
    item_o.ob_bits      = ~onboard_levels_i & cfg_i.onboard_col_mask & ROW_MASK;
    item_o.now_ms       = now_ms_i;
  end

endmodule

/* hw/rtl/kmsd_back.sv */
module kmsd_back
  import kmsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DEB_W-1:0] debounce_ms_i,
  input  logic             valid_i,
  input  item_t            item_i,
  output logic             take_o,
  output result_t          result_o,
  output logic             empty_o,
  input  logic             pop_i
);

  logic [COL_W-1:0]   raw_q [ROWS];
  logic [COL_W-1:0]   raw_d [ROWS];
  logic [COL_W-1:0]   stable_q [ROWS];
  logic [COL_W-1:0]   stable_d [ROWS];
  logic               settling_q, settling_d;
  logic [TIME_W-1:0]  settle_start_q, settle_start_d;
  logic               fault_q, fault_d;
  logic [RETRY_W-1:0] retry_cnt_q, retry_cnt_d;

  result_t            obuf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  owr_ptr_q, ord_ptr_q;
  logic [QCNT_W-1:0]  ocnt_q;
  logic               out_pop;

  logic               upd;
  logic [ROW_W-1:0]   row;
  logic [RETRY_W-1:0] retry_inc;
  logic               retry_hit;
  logic               flag_a;
  logic               flag_b;
  logic [COL_W-1:0]   raw;
  logic               changed;
  logic               settling_a;
  logic [TIME_W-1:0]  start_a;
  logic [TIME_W-1:0]  elapsed;
  logic               commit;
  result_t            res;

  assign take_o  = valid_i && (ocnt_q != QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (ocnt_q == '0);
  assign out_pop = pop_i && !empty_o;
  assign result_o = obuf_q[ord_ptr_q];

  always_comb begin
    row = item_i.row_index;
    upd = take_o && item_i.in_range;

    retry_inc = retry_cnt_q + 1'b1;
    retry_hit = (row == FIRST_ROW) && fault_q && (retry_inc == '0);
    // A retry hands the fault flag to this item's acknowledge.
    flag_a = retry_hit ? !item_i.expander_ack : fault_q;
    flag_b = flag_a || !item_i.expander_ack;

    raw = item_i.ob_bits;
    if (!flag_a && item_i.expander_ack) begin
      raw = raw | (COL_W'(item_i.exp_bits) & ROW_MASK);
    end

    changed    = (raw != raw_q[row]);
    settling_a = settling_q || changed;
    start_a    = changed ? item_i.now_ms : settle_start_q;
    elapsed    = item_i.now_ms - start_a;
    commit     = (row == LAST_ROW) && settling_a &&
                 (elapsed > TIME_W'(debounce_ms_i));

    for (int i = 0; i < ROWS; i++) begin
      raw_d[i] = (upd && (row == ROW_W'(i))) ? raw : raw_q[i];
    end
    for (int i = 0; i < ROWS; i++) begin
      stable_d[i] = (upd && commit) ? raw_d[i] : stable_q[i];
    end

    settling_d     = settling_q;
    settle_start_d = settle_start_q;
    fault_d        = fault_q;
    retry_cnt_d    = retry_cnt_q;
    if (upd) begin
      settling_d     = settling_a && !commit;
      settle_start_d = start_a;
      fault_d        = flag_b;
      if ((row == FIRST_ROW) && fault_q) begin
        retry_cnt_d = retry_inc;
      end
    end

    if (item_i.in_range) begin
      res.debounced_row  = stable_d[row];
      res.raw_changed    = changed;
      res.committed      = commit;
      res.expander_fault = flag_b;
      res.retry_request  = retry_hit;
    end else begin
      res.debounced_row  = '0;
      res.raw_changed    = 1'b0;
      res.committed      = 1'b0;
      res.expander_fault = fault_q;
      res.retry_request  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        raw_q[i]    <= '0;
        stable_q[i] <= '0;
      end
      settling_q     <= 1'b0;
      settle_start_q <= '0;
      fault_q        <= 1'b0;
      retry_cnt_q    <= '0;
      owr_ptr_q      <= '0;
      ord_ptr_q      <= '0;
      ocnt_q         <= '0;
    end else begin
      raw_q          <= raw_d;
      stable_q       <= stable_d;
      settling_q     <= settling_d;
      settle_start_q <= settle_start_d;
      fault_q        <= fault_d;
      retry_cnt_q    <= retry_cnt_d;
      owr_ptr_q      <= take_o ? owr_ptr_q + 1'b1 : owr_ptr_q;
      ord_ptr_q      <= out_pop ? ord_ptr_q + 1'b1 : ord_ptr_q;
      ocnt_q         <= ocnt_q + QCNT_W'(take_o) - QCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      obuf_q[owr_ptr_q] <= res;
    end
  end

endmodule

/* hw/rtl/key_matrix_scan_debounce.sv */
// A row reading pushed into the input queue waits there until the back end takes it, then
// moves to the result buffer and shows on the result ports from then on until popped.
// Throughput: one item per cycle while the result buffer has room, set by the back end
// updating its state as it takes each item.
// Reset (rst_ni low, asynchronous) empties both queues, clears the raw and debounced
// matrices, the settle timer, the fault flag and the retry counter, and loads 5/0/all ones.
module key_matrix_scan_debounce
  import kmsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,

  // Row readings.
  input  logic                  push,
  output logic                  full,
  input  logic [ROW_W-1:0]      row_index_i,
  input  logic [EXP_W-1:0]      expander_levels_i,
  input  logic                  expander_ack_i,
  input  logic [COL_W-1:0]      onboard_levels_i,
  input  logic [TIME_W-1:0]     now_ms_i,

  // Results.
  output logic                  empty,
  input  logic                  pop,
  output logic [COL_W-1:0]      debounced_row_o,
  output logic                  raw_changed_o,
  output logic                  committed_o,
  output logic                  expander_fault_o,
  output logic                  retry_request_o
);

  // Configuration registers: debounce 5 ms, expander mask 0 and onboard mask all
  // ones after reset. The user must write them only while the block is idle; the block
  // does not enforce this, and the front and back ends use them without any shadowing.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DEBOUNCE_MS: cfg_d.debounce_ms       = cfg_wdata_i[DEB_W-1:0];
        CFG_EXP_MASK:    cfg_d.expander_col_mask = cfg_wdata_i[EXP_W-1:0];
        CFG_OB_MASK:     cfg_d.onboard_col_mask  = cfg_wdata_i[COL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DEBOUNCE_RESET;
      cfg_q.expander_col_mask <= EXP_MASK_RESET;
      cfg_q.onboard_col_mask  <= OB_MASK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end inverts and masks the column levels and flags rows that
  // lie outside the matrix. This needs no state, so it runs on the port side
  // of the queue and every waiting item is already classified.
  item_t front_item;

  kmsd_front u_front (
    .cfg_i             (cfg_q),
    .row_index_i       (row_index_i),
    .expander_levels_i (expander_levels_i),
    .expander_ack_i    (expander_ack_i),
    .onboard_levels_i  (onboard_levels_i),
    .now_ms_i          (now_ms_i),
    .item_o            (front_item)
  );

  // A short queue parts the input handshake from the back end, so a stalled
  // result side does not reach the input until the queue fills.
  item_t q_item;
  logic  q_empty;
  logic  q_take;

  kmsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_take),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  // The back end holds the raw and debounced matrices, the global settle
  // timer and the expander fault and retry logic. It takes one item per
  // cycle while its result buffer has room and writes the result there.
  result_t res;

  kmsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .debounce_ms_i (cfg_q.debounce_ms),
    .valid_i       (!q_empty),
    .item_i        (q_item),
    .take_o        (q_take),
    .result_o      (res),
    .empty_o       (empty),
    .pop_i         (pop)
  );

  assign debounced_row_o  = res.debounced_row;
  assign raw_changed_o    = res.raw_changed;
  assign committed_o      = res.committed;
  assign expander_fault_o = res.expander_fault;
  assign retry_request_o  = res.retry_request;

endmodule

/* hw/rtl/kmsd_checker.sv */
`include "key_matrix_scan_debounce_assert.svh"

module kmsd_checker
  import kmsd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [COL_W-1:0] debounced_row_o,
  input logic             raw_changed_o,
  input logic             committed_o,
  input logic             expander_fault_o,
  input logic             retry_request_o
);

  // Everything the result side shows, gathered for the stability check.
  logic [COL_W+3:0] result_bits;

  assign result_bits = {debounced_row_o, raw_changed_o, committed_o, expander_fault_o,
                        retry_request_o};

  // Reset leaves both sides empty and ready.
  `KMSD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (empty && !full), "reset left a queue busy")

  // The input queue can only fill while results back up behind it.
  `KMSD_ASSERT(a_full_needs_results, full |-> !empty, "input full with no result waiting")

  // A waiting result that is not taken stays.
  `KMSD_ASSERT(a_result_stays, (!empty && !pop) |=> !empty, "waiting result dropped")

  // A waiting result that is not taken keeps its value.
  `KMSD_ASSERT(a_result_stable, (!empty && !pop) |=> $stable(result_bits), "result changed")

endmodule

bind key_matrix_scan_debounce kmsd_checker u_kmsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .debounced_row_o  (debounced_row_o),
  .raw_changed_o    (raw_changed_o),
  .committed_o      (committed_o),
  .expander_fault_o (expander_fault_o),
  .retry_request_o  (retry_request_o)
);
